[src/sensor_frame_crc_decoder_macros.svh]
// Assertion macros for the sensor frame CRC decoder.
`ifndef SENSOR_FRAME_CRC_DECODER_MACROS_SVH
`define SENSOR_FRAME_CRC_DECODER_MACROS_SVH
`ifndef NO_ASSERTIONS
// Check that a condition implies another in the same cycle.
`define SFCD_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
// Check that a condition implies another in the next cycle.
`define SFCD_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define SFCD_ASSERT_SAME(lbl, ante, cons, msg)
`define SFCD_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

[src/sfcd_pkg.sv]
// Shared types, constants and the CRC step of the sensor frame CRC decoder.
package sfcd_pkg;

   localparam int unsigned SFCD_QUEUE_DEPTH = 2;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;

   // Byte positions within a reply frame
   localparam logic [2:0] IDX_FIRST     = 3'd0;
   localparam logic [2:0] IDX_HUM_HI    = 3'd2;
   localparam logic [2:0] IDX_HUM_LO    = 3'd3;
   localparam logic [2:0] IDX_TEMP_HI   = 3'd4;
   localparam logic [2:0] IDX_TEMP_LO   = 3'd5;
   localparam logic [2:0] IDX_CRC_BYTES = 3'd6;
   localparam logic [2:0] IDX_CRC_LO    = 3'd6;
   localparam logic [2:0] IDX_CRC_HI    = 3'd7;

   localparam logic STATUS_OK      = 1'b0;
   localparam logic STATUS_CRC_ERR = 1'b1;

   // Classified byte passed from front to back
   typedef struct packed {
      logic [7:0] rx_byte;
      logic [2:0] byte_index;
   } byte_item_type;

   // One decoded frame
   typedef struct packed {
      logic               status;
      logic        [15:0] humidity_tenths;
      logic signed [15:0] temperature_tenths;
      logic        [15:0] computed_crc;
   } frame_result_type;

   // Reflected CRC-16 over one byte, one bit per step
   function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

[src/sfcd_queue.sv]
// Small first-in first-out queue of registered slots.
module sfcd_queue #(
   parameter int unsigned DATA_WIDTH = 8,
   parameter int unsigned DEPTH      = 2
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  logic [DATA_WIDTH-1:0] wr_data,
   output logic                  full,
   input  logic                  pop,
   output logic [DATA_WIDTH-1:0] rd_data,
   output logic                  empty
);
   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   logic [DATA_WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]      count_ff,  count_in;
   logic                  do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = slot_ff[rd_ptr_ff];

   // Advance pointers with wrap at the queue depth
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed item
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

[src/sfcd_front.sv]
// Front end: accepts bytes and tags each with its position in the frame.
module sfcd_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  logic [7:0]             rx_byte,
   input  logic                   frame_start,
   output sfcd_pkg::byte_item_type item
);
   import sfcd_pkg::*;

   logic [2:0] byte_index_ff, byte_index_in;
   logic [2:0] cur_index;

   // Resynchronize to the first byte on a start flag
   assign cur_index       = frame_start ? IDX_FIRST : byte_index_ff;
   assign item.rx_byte    = rx_byte;
   assign item.byte_index = cur_index;
   assign byte_index_in   = accept ? cur_index + 3'd1 : byte_index_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_index_ff <= IDX_FIRST;
      end else begin
         byte_index_ff <= byte_index_in;
      end
   end

endmodule

[src/sfcd_back.sv]
// Back end: runs the CRC, captures the data words and builds the frame result.
module sfcd_back (
   input  logic                       clock,
   input  logic                       reset,
   input  sfcd_pkg::byte_item_type    item,
   input  logic                       item_empty,
   output logic                       item_pop,
   input  logic                       result_full,
   output logic                       result_push,
   output sfcd_pkg::frame_result_type result
);
   import sfcd_pkg::*;

   logic [15:0] crc_ff, crc_in;
   logic [15:0] humidity_ff, humidity_in;
   logic [15:0] temperature_ff, temperature_in;
   logic [7:0]  crc_low_ff, crc_low_in;
   logic [15:0] crc_base;
   logic [15:0] crc_next;
   logic [15:0] received_crc;
   logic [15:0] magnitude;
   logic        last_byte;

   // Hold the last byte while the result queue cannot take the frame result
   assign last_byte   = (item.byte_index == IDX_CRC_HI);
   assign item_pop    = !item_empty && (!last_byte || !result_full);
   assign result_push = item_pop && last_byte;

   // Restart the CRC on the first byte of a frame
   assign crc_base = (item.byte_index == IDX_FIRST) ? CRC_INIT : crc_ff;
   assign crc_next = crc_feed(crc_base, item.rx_byte);

   // Build the result from captured words
   assign received_crc              = {item.rx_byte, crc_low_ff};
   assign magnitude                 = {1'b0, temperature_ff[14:0]};
   assign result.status             = (received_crc == crc_ff) ? STATUS_OK : STATUS_CRC_ERR;
   assign result.humidity_tenths    = humidity_ff;
   assign result.temperature_tenths = temperature_ff[15] ? -magnitude : magnitude;
   assign result.computed_crc       = crc_ff;

   // Update CRC and captured fields by byte position
   always_comb begin
      crc_in         = crc_ff;
      humidity_in    = humidity_ff;
      temperature_in = temperature_ff;
      crc_low_in     = crc_low_ff;
      if (item_pop) begin
         if (item.byte_index < IDX_CRC_BYTES) begin
            crc_in = crc_next;
         end
         case (item.byte_index)
            IDX_HUM_HI:  humidity_in[15:8]    = item.rx_byte;
            IDX_HUM_LO:  humidity_in[7:0]     = item.rx_byte;
            IDX_TEMP_HI: temperature_in[15:8] = item.rx_byte;
            IDX_TEMP_LO: temperature_in[7:0]  = item.rx_byte;
            IDX_CRC_LO:  crc_low_in           = item.rx_byte;
            IDX_CRC_HI:  crc_in               = CRC_INIT;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff         <= CRC_INIT;
         humidity_ff    <= '0;
         temperature_ff <= '0;
         crc_low_ff     <= '0;
      end else begin
         crc_ff         <= crc_in;
         humidity_ff    <= humidity_in;
         temperature_ff <= temperature_in;
         crc_low_ff     <= crc_low_in;
      end
   end

endmodule

[src/sensor_frame_crc_decoder.sv]
// Top level of the sensor frame CRC decoder.
//
// Input queue side: drive req_rx_byte and req_frame_start with req_push; a
// byte is taken on a clock edge with req_push high and req_full low.
// req_frame_start marks byte 0 of an 8-byte reply and drops any partial frame.
// Result queue side: while rsp_empty is low the oldest frame result is on the
// rsp_ ports; raise rsp_pop to take it. One result follows each eighth byte.
// Throughput is one byte per cycle while the result queue has room: the CRC advances a whole byte per cycle.
// From the req_ to the rsp_ ports, byte 7 is registered in the byte queue and
// its result in the result queue: the CRC and capture logic works straight from
// the head of the byte queue and pushes the result when it pops byte 7.
// A byte queue of QUEUE_DEPTH entries separates the classifying front from
// the CRC stage, and a result queue of the same depth holds finished frames.
// When the receiver stalls, the result queue fills, the CRC stage holds its
// last byte, the byte queue fills and req_full rises.
// Reset empties both queues, sets the frame position to byte 0 and the CRC to
// its initial value.
module sensor_frame_crc_decoder #(
   parameter int unsigned QUEUE_DEPTH = sfcd_pkg::SFCD_QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  logic [7:0]         req_rx_byte,
   input  logic               req_frame_start,
   input  logic               rsp_pop,
   output logic               rsp_empty,
   output logic               rsp_status,
   output logic [15:0]        rsp_humidity_tenths,
   output logic signed [15:0] rsp_temperature_tenths,
   output logic [15:0]        rsp_computed_crc
);
   import sfcd_pkg::*;
   `include "sensor_frame_crc_decoder_macros.svh"

   localparam int unsigned ITEM_W   = $bits(byte_item_type);
   localparam int unsigned RESULT_W = $bits(frame_result_type);

   byte_item_type    front_item, back_item;
   frame_result_type back_result, out_result;
   logic             req_accept;
   logic             item_empty, item_pop;
   logic             result_full, result_push;
   logic [ITEM_W-1:0]   back_item_bits;
   logic [RESULT_W-1:0] out_result_bits;

   assign req_accept = req_push && !req_full;

   sfcd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (req_accept),
      .rx_byte     (req_rx_byte),
      .frame_start (req_frame_start),
      .item        (front_item)
   );

   sfcd_queue #(
      .DATA_WIDTH (ITEM_W),
      .DEPTH      (QUEUE_DEPTH)
   ) u_item_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (req_push),
      .wr_data (front_item),
      .full    (req_full),
      .pop     (item_pop),
      .rd_data (back_item_bits),
      .empty   (item_empty)
   );

   assign back_item = byte_item_type'(back_item_bits);

   sfcd_back u_back (
      .clock       (clock),
      .reset       (reset),
      .item        (back_item),
      .item_empty  (item_empty),
      .item_pop    (item_pop),
      .result_full (result_full),
      .result_push (result_push),
      .result      (back_result)
   );

   sfcd_queue #(
      .DATA_WIDTH (RESULT_W),
      .DEPTH      (QUEUE_DEPTH)
   ) u_result_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (result_push),
      .wr_data (back_result),
      .full    (result_full),
      .pop     (rsp_pop),
      .rd_data (out_result_bits),
      .empty   (rsp_empty)
   );

   assign out_result             = frame_result_type'(out_result_bits);
   assign rsp_status             = out_result.status;
   assign rsp_humidity_tenths    = out_result.humidity_tenths;
   assign rsp_temperature_tenths = out_result.temperature_tenths;
   assign rsp_computed_crc       = out_result.computed_crc;

   // Checks
   `SFCD_ASSERT_SAME(a_start_is_first, req_accept && req_frame_start, front_item.byte_index == IDX_FIRST, "start byte not tagged as first")
   `SFCD_ASSERT_SAME(a_result_on_last, result_push, item_pop && back_item.byte_index == IDX_CRC_HI, "result without last byte")
   `SFCD_ASSERT_SAME(a_pop_not_empty, item_pop, !item_empty && !(result_push && result_full), "back stage pops illegally")
   `SFCD_ASSERT_NEXT(a_result_visible, result_push, !rsp_empty, "pushed result not visible")

endmodule
